>>> rtl/abg_pkg.sv
// Shared types, constants and helpers for the adaptive bitrate governor.
`default_nettype none

package abg_pkg;

	localparam int RATE_W   = 20;
	localparam int CNT_W    = 8;
	localparam int CD_W     = 4;
	localparam int RATIO_W  = 14;
	localparam int CPU_W    = 10;

	// Candidate rate datapath widths.
	localparam int PROD_W   = 27;
	localparam int DIVN_W   = 24;
	localparam int RECIP_W  = 25;
	localparam int MUL_W    = DIVN_W + RECIP_W;
	localparam int DIV_SH   = 34;
	localparam int QUO_W    = MUL_W - DIV_SH;
	localparam int CAND_W   = 21;

	// floor(n / 625) == (n * RECIP) >> 34 for every n below 2**24.
	localparam logic [RECIP_W-1:0] RECIP = 25'd27487791;

	localparam logic [PROD_W-1:0] FACT_SEVERE = 27'd78;
	localparam logic [PROD_W-1:0] FACT_PRESS  = 27'd85;
	localparam logic [PROD_W-1:0] FACT_RAISE  = 27'd106;
	localparam logic [PROD_W-1:0] CEIL_BIAS   = 27'd4999;
	localparam logic [CAND_W-1:0] RATE_STEP   = 21'd50;

	localparam logic [RATE_W-1:0] RATE_FLOOR    = 20'd1000;
	localparam logic [RATE_W-1:0] MAX_RESET     = 20'd6000;
	localparam logic [RATE_W-1:0] MIN_RESET     = 20'd1000;

	localparam logic [CPU_W-1:0]   CPU_LIMIT    = 10'd850;
	localparam logic [RATIO_W-1:0] MEM_LIMIT    = 14'd9200;
	localparam logic [RATIO_W-1:0] RUT_LIMIT    = 14'd9000;
	localparam logic [RATIO_W-1:0] LAG_LIMIT    = 14'd200;
	localparam logic [RATIO_W-1:0] CONG_SEVERE  = 14'd3500;
	localparam logic [RATIO_W-1:0] CONG_PRESS   = 14'd1500;
	localparam logic [RATIO_W-1:0] CONG_GOOD    = 14'd500;
	localparam logic [RATIO_W-1:0] DROP_SEVERE  = 14'd200;
	localparam logic [RATIO_W-1:0] DROP_PRESS   = 14'd50;
	localparam logic [RATIO_W-1:0] DROP_GOOD    = 14'd10;

	localparam logic [CNT_W-1:0] CNT_MAX        = 8'd255;
	localparam logic [CNT_W-1:0] HOST_LOAD_TRIP = 8'd3;
	localparam logic [CNT_W-1:0] HOST_GOOD_TRIP = 8'd15;
	localparam logic [CNT_W-1:0] NET_SEV_TRIP   = 8'd2;
	localparam logic [CNT_W-1:0] NET_LOAD_TRIP  = 8'd3;
	localparam logic [CNT_W-1:0] NET_GOOD_TRIP  = 8'd25;

	localparam logic [CD_W-1:0] CD_DECREASE = 4'd8;
	localparam logic [CD_W-1:0] CD_INCREASE = 4'd10;
	localparam logic [CD_W-1:0] CD_LIMIT    = 4'd10;

	typedef enum logic [0:0] {
		REG_MAX_BITRATE = 1'b0,
		REG_MIN_BITRATE = 1'b1
	} reg_index_t;

	// Input sample, last field in the lowest bits.
	typedef struct packed {
		logic               pad;
		logic [RATIO_W-1:0] drop_ratio;
		logic [RATIO_W-1:0] congestion;
		logic               is_streaming;
		logic [RATIO_W-1:0] encode_lag;
		logic [RATIO_W-1:0] render_lag;
		logic [RATIO_W-1:0] render_utilization;
		logic [RATIO_W-1:0] memory_pressure;
		logic [CPU_W-1:0]   cpu_load;
	} sample_t;

	// Result item, last field in the lowest bits.
	typedef struct packed {
		logic              severe_network;
		logic              constrained_changed;
		logic              constrained;
		logic              bitrate_changed;
		logic [RATE_W-1:0] bitrate;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + 8'd1;
	endfunction

endpackage

`default_nettype wire

>>> rtl/adaptive_bitrate_governor.sv
// Adaptive bitrate governor: host-load hysteresis and network-driven bitrate control.
// A sample passes through the input register and then the result register.
// Throughput: one sample per cycle while the result stream does not stall; a streaming
// sample waits after reset or a limit register write, while the 3-stage candidate-rate
// pipeline refills (rate times factor, reciprocal multiply, times 50).
// Reset (arst_n low, asynchronous) loads limits 6000/1000 kbps, rate 6000, clears the
// counters, cooldown and the constrained flag, and empties both stream registers.
`default_nettype none

module adaptive_bitrate_governor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream. tdata fields from bit 0 up: cpu_load, memory_pressure,
	// render_utilization, render_lag, encode_lag, is_streaming, congestion,
	// drop_ratio, one zero pad bit.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,
	// Result stream. tdata fields from bit 0 up: bitrate, bitrate_changed,
	// constrained, constrained_changed, severe_network.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,
	// Limit register write port.
	input  wire logic        cfg_wr_en,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [19:0] cfg_wdata
);

	localparam int RW = abg_pkg::RATE_W;
	localparam int CW = abg_pkg::CNT_W;

	// Limit registers and the effective limits derived from them at write time.
	logic [RW-1:0] max_q, min_q, eff_hi_q, eff_lo_q;
	logic [RW-1:0] new_max, new_min, new_hi, new_lo_raw, new_lo;
	logic          cfg_hit;

	// Governor state.
	logic [RW-1:0]               rate_q;
	logic                        constrained_q;
	logic [CW-1:0]               host_load_q, host_good_q, net_load_q, net_good_q;
	logic [abg_pkg::CD_W-1:0]    cooldown_q;

	// Stream registers.
	logic             in_valid_s1;
	abg_pkg::sample_t in_data_s1;
	logic             out_valid_q;
	abg_pkg::result_t out_data_q;

	// Candidate-rate pipeline, recomputed from rate_q whenever it changes.
	logic [abg_pkg::PROD_W-1:0] p_sev, p_prs, p_rse;
	logic [abg_pkg::DIVN_W-1:0] n_sev_s1, n_prs_s1, n_rse_s1;
	logic [abg_pkg::MUL_W-1:0]  m_sev, m_prs, m_rse;
	logic [abg_pkg::QUO_W-1:0]  q_sev_s2, q_prs_s2, q_rse_s2;
	logic [abg_pkg::CAND_W-1:0] c_sev, c_prs, c_rse;
	logic [RW-1:0]              cand_sev_s3, cand_prs_s3;
	logic [abg_pkg::CAND_W-1:0] cand_rse_s3;
	logic [1:0]                 cand_age_q;
	logic                       cand_ok;

	// Next-state values for one sample.
	logic                     fire, stall;
	logic                     host_p, severe, press, good;
	logic [CW-1:0]            host_load_n, host_good_n, net_load_n, net_good_n;
	logic                     constrained_n, mode_chg;
	logic [abg_pkg::CD_W-1:0] cd_dec, cooldown_n;
	logic [RW-1:0]            rate_n, dec_cand, dec_nx, inc_nx;
	logic                     rate_chg;
	logic [CW-1:0]            load_trip;
	abg_pkg::result_t         result;

	// ---------------------------------------------------------------------
	// Configuration: the write computes the new effective limits directly, so
	// the reload of the rate can use them in the same edge.
	// ---------------------------------------------------------------------
	always_comb begin
		cfg_hit = 1'b0;
		new_max = max_q;
		new_min = min_q;
		case (abg_pkg::reg_index_t'(cfg_index))
			abg_pkg::REG_MAX_BITRATE: begin
				cfg_hit = cfg_wr_en;
				new_max = cfg_wdata;
			end
			abg_pkg::REG_MIN_BITRATE: begin
				cfg_hit = cfg_wr_en;
				new_min = cfg_wdata;
			end
			default: begin
				cfg_hit = 1'b0;
			end
		endcase
		new_hi     = (new_max < abg_pkg::RATE_FLOOR) ? abg_pkg::RATE_FLOOR : new_max;
		new_lo_raw = (new_min < abg_pkg::RATE_FLOOR) ? abg_pkg::RATE_FLOOR : new_min;
		new_lo     = (new_lo_raw > new_hi) ? new_hi : new_lo_raw;
	end

	// ---------------------------------------------------------------------
	// Candidate rates. Each candidate is floor(rate * F / 5000) * 50 for a
	// decrease and ceil(rate * 106 / 5000) * 50 for an increase. The division
	// by 5000 drops three low bits and then divides by 625 through an exact
	// reciprocal multiply. The pipeline is three stages deep; cand_age_q
	// counts the cycles since rate_q last moved. A rate change always starts
	// a cooldown of at least 8 samples, so only reset or a limit write can
	// make a sample wait for the candidates.
	// ---------------------------------------------------------------------
	assign p_sev = abg_pkg::PROD_W'(rate_q) * abg_pkg::FACT_SEVERE;
	assign p_prs = abg_pkg::PROD_W'(rate_q) * abg_pkg::FACT_PRESS;
	assign p_rse = abg_pkg::PROD_W'(rate_q) * abg_pkg::FACT_RAISE + abg_pkg::CEIL_BIAS;

	assign m_sev = abg_pkg::MUL_W'(n_sev_s1) * abg_pkg::MUL_W'(abg_pkg::RECIP);
	assign m_prs = abg_pkg::MUL_W'(n_prs_s1) * abg_pkg::MUL_W'(abg_pkg::RECIP);
	assign m_rse = abg_pkg::MUL_W'(n_rse_s1) * abg_pkg::MUL_W'(abg_pkg::RECIP);

	assign c_sev = abg_pkg::CAND_W'(q_sev_s2) * abg_pkg::RATE_STEP;
	assign c_prs = abg_pkg::CAND_W'(q_prs_s2) * abg_pkg::RATE_STEP;
	assign c_rse = abg_pkg::CAND_W'(q_rse_s2) * abg_pkg::RATE_STEP;

	always_ff @(posedge clk) begin
		n_sev_s1    <= p_sev[abg_pkg::PROD_W-1:3];
		n_prs_s1    <= p_prs[abg_pkg::PROD_W-1:3];
		n_rse_s1    <= p_rse[abg_pkg::PROD_W-1:3];
		q_sev_s2    <= m_sev[abg_pkg::MUL_W-1:abg_pkg::DIV_SH];
		q_prs_s2    <= m_prs[abg_pkg::MUL_W-1:abg_pkg::DIV_SH];
		q_rse_s2    <= m_rse[abg_pkg::MUL_W-1:abg_pkg::DIV_SH];
		// Decrease candidates are below the rate, so they fit the rate width.
		cand_sev_s3 <= c_sev[RW-1:0];
		cand_prs_s3 <= c_prs[RW-1:0];
		cand_rse_s3 <= c_rse;
	end

	assign cand_ok = (cand_age_q == 2'd3);

	// ---------------------------------------------------------------------
	// Per-sample decision logic, between the input register and the result
	// register.
	// ---------------------------------------------------------------------
	always_comb begin
		host_p = (in_data_s1.cpu_load >= abg_pkg::CPU_LIMIT)
			|| (in_data_s1.memory_pressure >= abg_pkg::MEM_LIMIT)
			|| (in_data_s1.render_utilization >= abg_pkg::RUT_LIMIT)
			|| (in_data_s1.render_lag >= abg_pkg::LAG_LIMIT)
			|| (in_data_s1.encode_lag >= abg_pkg::LAG_LIMIT);

		host_load_n = host_p ? abg_pkg::sat_inc(host_load_q) : '0;
		host_good_n = host_p ? '0 : abg_pkg::sat_inc(host_good_q);

		constrained_n = constrained_q;
		mode_chg      = 1'b0;
		if (!constrained_q && host_load_n >= abg_pkg::HOST_LOAD_TRIP) begin
			constrained_n = 1'b1;
			mode_chg      = 1'b1;
		end else if (constrained_q && host_good_n >= abg_pkg::HOST_GOOD_TRIP) begin
			constrained_n = 1'b0;
			mode_chg      = 1'b1;
		end

		severe = (in_data_s1.congestion >= abg_pkg::CONG_SEVERE)
			|| (in_data_s1.drop_ratio >= abg_pkg::DROP_SEVERE);
		press  = severe || (in_data_s1.congestion >= abg_pkg::CONG_PRESS)
			|| (in_data_s1.drop_ratio >= abg_pkg::DROP_PRESS);
		good   = (in_data_s1.congestion < abg_pkg::CONG_GOOD)
			&& (in_data_s1.drop_ratio < abg_pkg::DROP_GOOD);

		cd_dec    = (cooldown_q != '0) ? cooldown_q - 4'd1 : '0;
		load_trip = severe ? abg_pkg::NET_SEV_TRIP : abg_pkg::NET_LOAD_TRIP;
		dec_cand  = severe ? cand_sev_s3 : cand_prs_s3;
		dec_nx    = (dec_cand < eff_lo_q) ? eff_lo_q : dec_cand;
		inc_nx    = (cand_rse_s3 > abg_pkg::CAND_W'(eff_hi_q)) ? eff_hi_q
			: cand_rse_s3[RW-1:0];

		rate_n     = rate_q;
		rate_chg   = 1'b0;
		cooldown_n = cooldown_q;
		net_load_n = '0;
		net_good_n = '0;

		if (in_data_s1.is_streaming) begin
			cooldown_n = cd_dec;
			if (press) begin
				net_load_n = abg_pkg::sat_inc(net_load_q);
			end else if (good) begin
				net_good_n = abg_pkg::sat_inc(net_good_q);
			end else begin
				net_load_n = (net_load_q != '0) ? net_load_q - 8'd1 : '0;
			end

			if (cd_dec == '0 && net_load_n >= load_trip && rate_q > eff_lo_q) begin
				if (dec_nx < rate_q) begin
					rate_n     = dec_nx;
					rate_chg   = 1'b1;
					cooldown_n = abg_pkg::CD_DECREASE;
				end
				net_load_n = '0;
			end else if (cd_dec == '0 && net_good_n >= abg_pkg::NET_GOOD_TRIP
					&& rate_q < eff_hi_q) begin
				if (inc_nx > rate_q) begin
					rate_n     = inc_nx;
					rate_chg   = 1'b1;
					cooldown_n = abg_pkg::CD_INCREASE;
				end
				net_good_n = '0;
			end
		end

		result.bitrate             = rate_n;
		result.bitrate_changed     = rate_chg;
		result.constrained         = constrained_n;
		result.constrained_changed = mode_chg;
		result.severe_network      = in_data_s1.is_streaming & severe;
	end

	// A streaming sample that may reach a rate decision needs settled
	// candidates; that is only possible when the cooldown runs out now.
	assign stall = in_data_s1.is_streaming && (cd_dec == '0) && !cand_ok;

	// ---------------------------------------------------------------------
	// Handshake: the input register takes a new transaction when it is empty
	// or when its sample moves on to the result register in the same cycle.
	// ---------------------------------------------------------------------
	assign fire          = in_valid_s1 && (!out_valid_q || m_axis_tready) && !stall;
	assign s_axis_tready = !in_valid_s1 || fire;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				in_valid_s1 <= s_axis_tvalid;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_data_s1 <= abg_pkg::sample_t'(s_axis_tdata);
		end
		if (fire) begin
			out_data_q <= result;
		end
	end

	// ---------------------------------------------------------------------
	// State registers. A limit write reloads the rate from the effective
	// maximum and clears the counters and cooldown; the flag is kept.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q         <= abg_pkg::MAX_RESET;
			min_q         <= abg_pkg::MIN_RESET;
			eff_hi_q      <= abg_pkg::MAX_RESET;
			eff_lo_q      <= abg_pkg::MIN_RESET;
			rate_q        <= abg_pkg::MAX_RESET;
			constrained_q <= 1'b0;
			host_load_q   <= '0;
			host_good_q   <= '0;
			net_load_q    <= '0;
			net_good_q    <= '0;
			cooldown_q    <= '0;
			cand_age_q    <= '0;
		end else if (cfg_hit) begin
			max_q       <= new_max;
			min_q       <= new_min;
			eff_hi_q    <= new_hi;
			eff_lo_q    <= new_lo;
			rate_q      <= new_hi;
			host_load_q <= '0;
			host_good_q <= '0;
			net_load_q  <= '0;
			net_good_q  <= '0;
			cooldown_q  <= '0;
			cand_age_q  <= '0;
		end else begin
			if (fire) begin
				rate_q        <= rate_n;
				constrained_q <= constrained_n;
				host_load_q   <= host_load_n;
				host_good_q   <= host_good_n;
				net_load_q    <= net_load_n;
				net_good_q    <= net_good_n;
				cooldown_q    <= cooldown_n;
			end
			if (fire && rate_chg) begin
				cand_age_q <= '0;
			end else if (!cand_ok) begin
				cand_age_q <= cand_age_q + 2'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// The bitrate never leaves the effective limits.
	a_rate_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(rate_q >= eff_lo_q) && (rate_q <= eff_hi_q))
		else $error("bitrate outside effective limits");

	// The cooldown never exceeds the longest one that is loaded.
	a_cooldown_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cooldown_q <= abg_pkg::CD_LIMIT)
		else $error("cooldown out of range");

	// A rate step is only taken from settled candidates.
	a_rate_step_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rate_chg) |-> cand_ok)
		else $error("rate step from unsettled candidates");

	// With both registers full and the output stalled, no transaction is taken.
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while pipeline is full");

	// A rate step starts a cooldown long enough to cover the candidate refill.
	a_step_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rate_chg && !cfg_hit) |=> (cooldown_q >= abg_pkg::CD_DECREASE))
		else $error("rate step without cooldown");
`endif

endmodule

`default_nettype wire
